// ===== src/msca_pkg.sv =====
// ----------------------------------------------------------------------------
// msca_pkg
// operation codes, status codes, limits and the control bundle of the alu
// ----------------------------------------------------------------------------
`default_nettype none
package msca_pkg;

	localparam logic [3:0] OP_EQ  = 4'd0;
	localparam logic [3:0] OP_NE  = 4'd1;
	localparam logic [3:0] OP_LT  = 4'd2;
	localparam logic [3:0] OP_GT  = 4'd3;
	localparam logic [3:0] OP_LE  = 4'd4;
	localparam logic [3:0] OP_GE  = 4'd5;
	localparam logic [3:0] OP_ADD = 4'd6;
	localparam logic [3:0] OP_SUB = 4'd7;
	localparam logic [3:0] OP_NEG = 4'd8;
	localparam logic [3:0] OP_MUL = 4'd9;
	localparam logic [3:0] OP_DIV = 4'd10;
	localparam logic [3:0] OP_SZS = 4'd11;
	localparam logic [3:0] OP_SZU = 4'd12;
	localparam logic [3:0] OP_SZA = 4'd13;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam logic [1:0] SZ_64 = 2'd3;

	localparam logic [63:0] SMAX_8   = 64'h7f;
	localparam logic [63:0] SMAX_16  = 64'h7fff;
	localparam logic [63:0] SMAX_32  = 64'h7fff_ffff;
	localparam logic [63:0] UMAX_8   = 64'hff;
	localparam logic [63:0] UMAX_16  = 64'hffff;
	localparam logic [63:0] UMAX_32  = 64'hffff_ffff;

	typedef struct packed {
		logic [3:0] op;
		logic       md_neg;
		logic       b_zero;
		logic       res_signed;
		logic       truth;
		logic [1:0] code;
		logic       code_valid;
		logic [1:0] status;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== src/msca_front.sv =====
// ----------------------------------------------------------------------------
// msca_front
// operand decode and the single-step operations, two pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none
module msca_front #(
	parameter int W = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [3:0]          op,
	input  wire logic [W-1:0]        a_raw,
	input  wire logic                a_sgn,
	input  wire logic [W-1:0]        b_raw,
	input  wire logic                b_sgn,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output msca_pkg::ctrl_t          out_ctrl,
	output logic [W-1:0]             out_x,
	output logic [W-1:0]             out_y,
	output logic [W-1:0]             out_acc
);

	localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

	// size query: {valid, code}
	function automatic logic [2:0] size_fit(input logic neg, input logic [63:0] mag,
			input logic [1:0] kind);
		logic [63:0] smax [4];
		logic [63:0] umax [4];
		logic [2:0]  res;
		logic        fits;
		smax = '{msca_pkg::SMAX_8, msca_pkg::SMAX_16, msca_pkg::SMAX_32,
			64'h7fff_ffff_ffff_ffff};
		umax = '{msca_pkg::UMAX_8, msca_pkg::UMAX_16, msca_pkg::UMAX_32,
			64'hffff_ffff_ffff_ffff};
		res = 3'b000;
		for (int k = 3; k >= 0; k--) begin
			if (neg) fits = (kind != 2'd1) && (mag <= smax[k] + 64'd1);
			else if (kind == 2'd0) fits = mag <= smax[k];
			else fits = mag <= umax[k];
			if (fits) res = {1'b1, 2'(k)};
		end
		return res;
	endfunction

	// stage 1: decode
	logic         v_s1;
	logic [3:0]   op_s1;
	logic         an_s1, bn_s1;
	logic [W-1:0] am_s1, bm_s1;
	logic [1:0]   ca_s1, cb_s1;
	logic         rdy_s1;

	logic         an_d, bn_d;
	assign an_d = a_sgn & a_raw[W-1];
	assign bn_d = b_sgn & b_raw[W-1];

	assign in_ready = !v_s1 || rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
			an_s1 <= an_d;
			bn_s1 <= bn_d;
			am_s1 <= an_d ? (~a_raw + 1'b1) : a_raw;
			bm_s1 <= bn_d ? (~b_raw + 1'b1) : b_raw;
			ca_s1 <= an_d ? 2'd0 : ((!a_sgn && a_raw[W-1]) ? 2'd2 : 2'd1);
			cb_s1 <= bn_d ? 2'd0 : ((!b_sgn && b_raw[W-1]) ? 2'd2 : 2'd1);
		end
	end

	// stage 2 logic
	logic         eq, lt, gt;
	logic         is_sub, nbn, same, age;
	logic [W:0]   sum;
	logic [W-1:0] dab, dba, rmag, rval, nval;
	logic         rneg, rok, nneg;
	logic [2:0]   sz;
	msca_pkg::ctrl_t c;
	logic [W-1:0] acc_d;

	always_comb begin
		eq = (an_s1 == bn_s1) && (am_s1 == bm_s1);
		if (an_s1 != bn_s1) lt = an_s1;
		else lt = an_s1 ? (am_s1 > bm_s1) : (am_s1 < bm_s1);
		gt = !eq && !lt;

		is_sub = op_s1 == msca_pkg::OP_SUB;
		nbn    = (is_sub && bm_s1 != '0) ? !bn_s1 : bn_s1;
		same   = an_s1 == nbn;
		sum    = {1'b0, am_s1} + {1'b0, bm_s1};
		dab    = am_s1 - bm_s1;
		dba    = bm_s1 - am_s1;
		age    = am_s1 >= bm_s1;
		if (same) begin
			rmag = sum[W-1:0];
			rneg = an_s1;
			rok  = !sum[W] && (!an_s1 || sum[W-1:0] <= HALF);
		end else begin
			rmag = age ? dab : dba;
			rneg = age ? an_s1 : nbn;
			rok  = 1'b1;
		end
		if (rmag == '0) rneg = 1'b0;
		// a negative difference below the signed range
		if (rneg && rmag > HALF) rok = 1'b0;
		rval = rneg ? (~rmag + 1'b1) : rmag;

		// negate: result negative when a is a non-zero non-negative value
		nneg = !an_s1 && am_s1 != '0;
		nval = nneg ? (~am_s1 + 1'b1) : am_s1;

		sz = 3'b000;
		case (op_s1)
			msca_pkg::OP_SZS: sz = size_fit(an_s1, 64'(am_s1), 2'd0);
			msca_pkg::OP_SZU: sz = size_fit(an_s1, 64'(am_s1), 2'd1);
			msca_pkg::OP_SZA: begin
				sz = size_fit(an_s1, 64'(am_s1), 2'd2);
				if (!sz[2]) sz = {1'b1, msca_pkg::SZ_64};
			end
			default: sz = 3'b000;
		endcase

		c            = '0;
		c.op         = op_s1;
		c.md_neg     = an_s1 ^ bn_s1;
		c.b_zero     = bm_s1 == '0;
		c.code       = sz[1:0];
		c.code_valid = sz[2];
		acc_d        = '0;
		case (op_s1)
			msca_pkg::OP_EQ: c.truth = eq;
			msca_pkg::OP_NE: c.truth = !eq;
			msca_pkg::OP_LT: c.truth = lt;
			msca_pkg::OP_GT: c.truth = gt;
			msca_pkg::OP_LE: c.truth = !gt;
			msca_pkg::OP_GE: c.truth = !lt;
			msca_pkg::OP_ADD, msca_pkg::OP_SUB: begin
				if (!rok) c.status = msca_pkg::ST_OVF;
				else begin
					acc_d = rval;
					if (is_sub) c.res_signed = ca_s1 <= cb_s1;
					else c.res_signed = (ca_s1 == 2'd0 || cb_s1 == 2'd0) &&
						ca_s1 != 2'd2 && cb_s1 != 2'd2;
				end
			end
			msca_pkg::OP_NEG: begin
				if (nneg) begin
					if (am_s1 <= HALF) begin
						acc_d        = nval;
						c.res_signed = 1'b1;
					end else c.status = msca_pkg::ST_OVF;
				end else if (am_s1 == HALF) begin
					acc_d = HALF;
				end else begin
					acc_d        = nval;
					c.res_signed = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// stage 2 register
	assign rdy_s1 = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (rdy_s1) out_valid <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && v_s1) begin
			out_ctrl <= c;
			out_x    <= am_s1;
			out_y    <= bm_s1;
			out_acc  <= acc_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/msca_cell.sv =====
// ----------------------------------------------------------------------------
// msca_cell
// one shift-add multiply step or one restoring divide step per cell
// ----------------------------------------------------------------------------
`default_nettype none
module msca_cell #(
	parameter int W = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire msca_pkg::ctrl_t in_ctrl,
	input  wire logic [W-1:0]    in_x,
	input  wire logic [W-1:0]    in_y,
	input  wire logic [W-1:0]    in_acc,
	input  wire logic [W-1:0]    in_rem,
	input  wire logic            in_big,
	input  wire logic            in_ovf,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output msca_pkg::ctrl_t      out_ctrl,
	output logic [W-1:0]         out_x,
	output logic [W-1:0]         out_y,
	output logic [W-1:0]         out_acc,
	output logic [W-1:0]         out_rem,
	output logic                 out_big,
	output logic                 out_ovf
);

	logic [W-1:0] x_n, y_n, acc_n, rem_n;
	logic         big_n, ovf_n, ge;
	logic [W:0]   add, r2, diff;

	always_comb begin
		x_n   = in_x;
		y_n   = in_y;
		acc_n = in_acc;
		rem_n = in_rem;
		big_n = in_big;
		ovf_n = in_ovf;
		add   = {1'b0, in_acc} + {1'b0, in_x};
		r2    = {in_rem, in_x[W-1]};
		diff  = r2 - {1'b0, in_y};
		ge    = r2 >= {1'b0, in_y};
		case (in_ctrl.op)
			msca_pkg::OP_MUL: begin
				// lsb of the multiplier selects the shifted multiplicand
				if (in_y[0]) begin
					acc_n = add[W-1:0];
					ovf_n = in_ovf | in_big | add[W];
				end
				big_n = in_big | in_x[W-1];
				x_n   = {in_x[W-2:0], 1'b0};
				y_n   = {1'b0, in_y[W-1:1]};
			end
			msca_pkg::OP_DIV: begin
				rem_n = ge ? diff[W-1:0] : r2[W-1:0];
				acc_n = {in_acc[W-2:0], ge};
				x_n   = {in_x[W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_ready) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_ctrl <= in_ctrl;
			out_x    <= x_n;
			out_y    <= y_n;
			out_acc  <= acc_n;
			out_rem  <= rem_n;
			out_big  <= big_n;
			out_ovf  <= ovf_n;
		end
	end

endmodule
`default_nettype wire

// ===== src/msca_back.sv =====
// ----------------------------------------------------------------------------
// msca_back
// result assembly and output register
// ----------------------------------------------------------------------------
`default_nettype none
module msca_back #(
	parameter int W = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire msca_pkg::ctrl_t in_ctrl,
	input  wire logic [W-1:0]    in_acc,
	input  wire logic            in_ovf,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output logic [63:0]          result_value,
	output logic                 result_signed,
	output logic                 compare_true,
	output logic [1:0]           size_code,
	output logic                 size_valid,
	output logic [1:0]           status
);

	localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] val;
	logic         sgn;
	logic [1:0]   st;
	logic         md;

	always_comb begin
		md  = in_ctrl.op == msca_pkg::OP_MUL || in_ctrl.op == msca_pkg::OP_DIV;
		val = in_acc;
		sgn = in_ctrl.res_signed;
		st  = in_ctrl.status;
		if (md) begin
			sgn = in_ctrl.md_neg;
			val = (in_ctrl.md_neg && in_acc != '0) ? (~in_acc + 1'b1) : in_acc;
			st  = msca_pkg::ST_OK;
			if (in_ctrl.op == msca_pkg::OP_DIV && in_ctrl.b_zero) st = msca_pkg::ST_DIV0;
			else if (in_ovf || (in_ctrl.md_neg && in_acc > HALF)) st = msca_pkg::ST_OVF;
			if (st != msca_pkg::ST_OK) begin
				val = '0;
				sgn = 1'b0;
			end
		end
	end

	assign in_ready = !rsp_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (in_ready) rsp_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_value  <= 64'(val);
			result_signed <= sgn;
			compare_true  <= in_ctrl.truth;
			size_code     <= in_ctrl.code;
			size_valid    <= in_ctrl.code_valid;
			status        <= st;
		end
	end

endmodule
`default_nettype wire

// ===== src/mixed_sign_checked_alu.sv =====
// ----------------------------------------------------------------------------
// mixed_sign_checked_alu
// overflow-checked alu for operands that each carry their own signedness
// ----------------------------------------------------------------------------
// channel  handshake             payload
// request  req_valid/req_stall   operation, a_value, a_signed, b_value, b_signed
// response rsp_valid/rsp_stall   result_value, result_signed, compare_true,
//                                size_code, size_valid, status
//
// one transaction per cycle while the response side does not stall; the path runs
// through a row of DATA_WIDTH multiply/divide cells (one quotient or multiplier bit each)
// every operation runs the full row so results leave in order
// arst_n clears the valid bits of all stages; payload registers are not reset
// a stage takes a new transaction whenever it is empty or its successor moves,
// so bubbles close up while the response side stalls
// ----------------------------------------------------------------------------
`default_nettype none
module mixed_sign_checked_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [3:0]  operation,
	input  wire logic [63:0] a_value,
	input  wire logic        a_signed,
	input  wire logic [63:0] b_value,
	input  wire logic        b_signed,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [63:0]      result_value,
	output logic             result_signed,
	output logic             compare_true,
	output logic [1:0]       size_code,
	output logic             size_valid,
	output logic [1:0]       status
);

	localparam int W = DATA_WIDTH;

	// links between the cells: index k feeds cell k
	logic            v    [0:W];
	logic            rdy  [0:W];
	msca_pkg::ctrl_t ctrl [0:W];
	logic [W-1:0]    x    [0:W];
	logic [W-1:0]    y    [0:W];
	logic [W-1:0]    acc  [0:W];
	logic [W-1:0]    rem  [0:W];
	logic            big  [0:W];
	logic            ovf  [0:W];
	logic            req_ready;

	assign req_stall = !req_ready;

	// decode, compares, add/sub, negate and size queries
	msca_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.op        (operation),
		.a_raw     (a_value[W-1:0]),
		.a_sgn     (a_signed),
		.b_raw     (b_value[W-1:0]),
		.b_sgn     (b_signed),
		.out_valid (v[0]),
		.out_ready (rdy[0]),
		.out_ctrl  (ctrl[0]),
		.out_x     (x[0]),
		.out_y     (y[0]),
		.out_acc   (acc[0])
	);

	// remainder and flags start clear for every transaction
	assign rem[0] = '0;
	assign big[0] = 1'b0;
	assign ovf[0] = 1'b0;

	for (genvar k = 0; k < W; k++) begin : g_cell
		msca_cell #(.W(W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[k]),
			.in_ready  (rdy[k]),
			.in_ctrl   (ctrl[k]),
			.in_x      (x[k]),
			.in_y      (y[k]),
			.in_acc    (acc[k]),
			.in_rem    (rem[k]),
			.in_big    (big[k]),
			.in_ovf    (ovf[k]),
			.out_valid (v[k+1]),
			.out_ready (rdy[k+1]),
			.out_ctrl  (ctrl[k+1]),
			.out_x     (x[k+1]),
			.out_y     (y[k+1]),
			.out_acc   (acc[k+1]),
			.out_rem   (rem[k+1]),
			.out_big   (big[k+1]),
			.out_ovf   (ovf[k+1])
		);
	end

	// product/quotient sign, overflow and divide-by-zero, then output register
	msca_back #(.W(W)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v[W]),
		.in_ready      (rdy[W]),
		.in_ctrl       (ctrl[W]),
		.in_acc        (acc[W]),
		.in_ovf        (ovf[W]),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.result_value  (result_value),
		.result_signed (result_signed),
		.compare_true  (compare_true),
		.size_code     (size_code),
		.size_valid    (size_valid),
		.status        (status)
	);

`ifndef SYNTH
	// a failed operation returns a cleared value
	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != msca_pkg::ST_OK |-> result_value == '0 && !result_signed)
		else $error("failed operation returned a value");

	// a size query gives neither a value nor a status
	a_size_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && size_valid |-> result_value == '0 && status == msca_pkg::ST_OK
			&& !compare_true)
		else $error("size query mixed with other results");

	// an invalid size reports code zero
	a_size_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !size_valid |-> size_code == 2'd0)
		else $error("size code without valid");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the mixed-signedness alu against a behavioural predictor: a table of
// directed cases, then random operations, with random gaps and stalls on both
// channels, a long response hold-off and a drain pause
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam int W = 64;
	localparam int LATENCY = W + 3;
	localparam int N_RANDOM = 830;
	localparam logic [64:0] HALF = 65'd1 << (W - 1);
	localparam logic [64:0] UMAX = (65'd1 << W) - 1;

	typedef struct packed {
		logic [3:0]  op;
		logic [63:0] a;
		logic        as;
		logic [63:0] b;
		logic        bs;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic        sgn;
		logic        truth;
		logic [1:0]  code;
		logic        valid;
		logic [1:0]  status;
	} alu_rsp_t;

	// magnitude/sign view of an operand, with its class (0 neg, 1 low, 2 high)
	typedef struct packed {
		logic        neg;
		logic [64:0] mag;
		logic [1:0]  cls;
	} mixed_num_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [3:0] operation = '0;
	logic [63:0] a_value = '0;
	logic a_signed = 1'b0;
	logic [63:0] b_value = '0;
	logic b_signed = 1'b0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	logic [63:0] result_value;
	logic result_signed;
	logic compare_true;
	logic [1:0] size_code;
	logic size_valid;
	logic [1:0] status;

	alu_rsp_t expected_results[$];
	int errors = 0;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;

	mixed_sign_checked_alu #(.DATA_WIDTH(W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .a_value(a_value), .a_signed(a_signed),
		.b_value(b_value), .b_signed(b_signed),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.result_value(result_value), .result_signed(result_signed),
		.compare_true(compare_true), .size_code(size_code),
		.size_valid(size_valid), .status(status)
	);

	always #6 clk = ~clk;

	function automatic mixed_num_t to_mixed(logic [63:0] raw, logic sgn);
		mixed_num_t n;
		n.neg = sgn & raw[W-1];
		n.mag = n.neg ? (65'd1 << W) - {1'b0, raw} : {1'b0, raw};
		n.cls = n.neg ? 2'd0 : (!sgn && raw[W-1]) ? 2'd2 : 2'd1;
		return n;
	endfunction

	// signed wide values make the range checks plain arithmetic
	function automatic logic signed [130:0] as_int(mixed_num_t n);
		return n.neg ? -$signed({66'd0, n.mag}) : $signed({66'd0, n.mag});
	endfunction

	function automatic void fit_size(logic signed [130:0] v, int kind,
			output logic [1:0] code, output logic ok);
		logic signed [130:0] lo, hi;
		code = '0;
		ok = 1'b0;
		for (int k = 0; k < 4; k++) begin
			lo = (kind == 1) ? 0 : -(131'sd1 <<< ((8 << k) - 1));
			hi = (kind == 0) ? (131'sd1 <<< ((8 << k) - 1)) - 1 : (131'sd1 <<< (8 << k)) - 1;
			if (!ok && v >= lo && v <= hi) begin
				code = k[1:0];
				ok = 1'b1;
			end
		end
	endfunction

	function automatic alu_rsp_t predict_alu(alu_req_t t);
		alu_rsp_t r;
		mixed_num_t x, y;
		logic signed [130:0] va, vb, v;
		logic ovf, neg_res;
		r = '0;
		x = to_mixed(t.a, t.as);
		y = to_mixed(t.b, t.bs);
		va = as_int(x);
		vb = as_int(y);
		ovf = 1'b0;
		case (t.op)
			msca_pkg::OP_EQ: r.truth = va == vb;
			msca_pkg::OP_NE: r.truth = va != vb;
			msca_pkg::OP_LT: r.truth = va < vb;
			msca_pkg::OP_GT: r.truth = va > vb;
			msca_pkg::OP_LE: r.truth = va <= vb;
			msca_pkg::OP_GE: r.truth = va >= vb;
			msca_pkg::OP_ADD, msca_pkg::OP_SUB, msca_pkg::OP_MUL, msca_pkg::OP_DIV,
			msca_pkg::OP_NEG: begin
				neg_res = (x.cls == 2'd0) != (y.cls == 2'd0);
				if (t.op == msca_pkg::OP_DIV && y.mag == 0) begin
					r.status = msca_pkg::ST_DIV0;
				end else begin
					case (t.op)
						msca_pkg::OP_ADD: v = va + vb;
						msca_pkg::OP_SUB: v = va - vb;
						msca_pkg::OP_NEG: v = -va;
						msca_pkg::OP_MUL: v = va * vb;
						default: v = neg_res ? -$signed({66'd0, x.mag / y.mag})
							: $signed({66'd0, x.mag / y.mag});
					endcase
					ovf = v > $signed({66'd0, UMAX}) || v < -$signed({66'd0, HALF});
					// an unsigned magnitude product above the range overflows even if signed
					if (t.op == msca_pkg::OP_MUL && x.mag * y.mag > {1'b0, UMAX})
						ovf = 1'b1;
					if (ovf) begin
						r.status = msca_pkg::ST_OVF;
					end else begin
						r.value = v[63:0];
						case (t.op)
							msca_pkg::OP_ADD: r.sgn = (x.cls == 0 || y.cls == 0) &&
								x.cls != 2 && y.cls != 2;
							msca_pkg::OP_SUB: r.sgn = x.cls <= y.cls;
							// the most negative value negated comes back unsigned
							msca_pkg::OP_NEG: r.sgn = !(v == $signed({66'd0, HALF}));
							default: r.sgn = neg_res;
						endcase
						// negation of a large unsigned value is out of range
						if (t.op == msca_pkg::OP_NEG && v < -$signed({66'd0, HALF})) begin
							r = '0;
							r.status = msca_pkg::ST_OVF;
						end
					end
				end
			end
			msca_pkg::OP_SZS: fit_size(va, 0, r.code, r.valid);
			msca_pkg::OP_SZU: fit_size(va, 1, r.code, r.valid);
			msca_pkg::OP_SZA: begin
				fit_size(va, 2, r.code, r.valid);
				if (!r.valid) begin
					r.code = msca_pkg::SZ_64;
					r.valid = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one transaction after a random gap, then wait for acceptance
	task automatic send_alu(alu_req_t t);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= t.op;
		a_value <= t.a;
		a_signed <= t.as;
		b_value <= t.b;
		b_signed <= t.bs;
		do @(posedge clk); while (req_stall);
		expected_results.insert(expected_results.size(), predict_alu(t));
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = v >> $urandom_range(0, 63);
			1: v = ~(v >> $urandom_range(0, 63));
			2: v = {63'd0, v[0]} | (v[1] ? 64'h8000_0000_0000_0000 : 64'd0);
			3: v = 64'hffff_ffff_ffff_ffff - {60'd0, v[3:0]};
			4: v = v >> $urandom_range(32, 63);
			default: ;
		endcase
		return v;
	endfunction

	// directed rows: operation, a, a signed, b, b signed, typed flag, written expectation
	typedef struct packed {
		alu_req_t req;
		logic     typed;
		alu_rsp_t rsp;
	} directed_row_t;

	directed_row_t directed_rows[] = '{
		'{'{msca_pkg::OP_EQ, 64'hffff_ffff_ffff_ffff, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b0},
			1'b1, '{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_NE, 64'd0, 1'b1, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_LT, 64'h8000_0000_0000_0000, 1'b1, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b1, 2'd0, 1'b0, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_GT, 64'h8000_0000_0000_0000, 1'b0, 64'h7fff_ffff_ffff_ffff, 1'b1},
			1'b0, '0},
		'{'{msca_pkg::OP_LE, 64'd5, 1'b1, 64'd5, 1'b0}, 1'b0, '0},
		'{'{msca_pkg::OP_GE, 64'hffff_ffff_ffff_fffe, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1},
			1'b0, '0},
		'{'{msca_pkg::OP_ADD, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd1, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OVF}},
		'{'{msca_pkg::OP_ADD, 64'hffff_ffff_ffff_ffff, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b1},
			1'b0, '0},
		'{'{msca_pkg::OP_ADD, 64'h8000_0000_0000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1},
			1'b1, '{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OVF}},
		'{'{msca_pkg::OP_SUB, 64'd0, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OVF}},
		'{'{msca_pkg::OP_SUB, 64'd3, 1'b0, 64'h8000_0000_0000_0000, 1'b1}, 1'b0, '0},
		'{'{msca_pkg::OP_NEG, 64'h8000_0000_0000_0000, 1'b1, 64'd0, 1'b0}, 1'b1,
			'{64'h8000_0000_0000_0000, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_NEG, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0}, 1'b0, '0},
		'{'{msca_pkg::OP_NEG, 64'h8000_0000_0000_0001, 1'b0, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OVF}},
		'{'{msca_pkg::OP_NEG, 64'd0, 1'b1, 64'd0, 1'b0}, 1'b0, '0},
		'{'{msca_pkg::OP_MUL, 64'h1_0000_0000, 1'b0, 64'h1_0000_0000, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OVF}},
		'{'{msca_pkg::OP_MUL, 64'h8000_0000_0000_0000, 1'b1, 64'd1, 1'b0}, 1'b0, '0},
		'{'{msca_pkg::OP_MUL, 64'h4000_0000_0000_0000, 1'b0, 64'hffff_ffff_ffff_fffe, 1'b1},
			1'b0, '0},
		'{'{msca_pkg::OP_DIV, 64'd7, 1'b0, 64'd0, 1'b1}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_DIV0}},
		'{'{msca_pkg::OP_DIV, 64'hffff_ffff_ffff_fff9, 1'b1, 64'd2, 1'b0}, 1'b0, '0},
		'{'{msca_pkg::OP_DIV, 64'h8000_0000_0000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1},
			1'b0, '0},
		'{'{msca_pkg::OP_SZS, 64'h80, 1'b0, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd1, 1'b1, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_SZS, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_SZU, 64'hffff_ffff_ffff_ff80, 1'b1, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, 2'd0, 1'b0, msca_pkg::ST_OK}},
		'{'{msca_pkg::OP_SZA, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd0, 1'b0}, 1'b1,
			'{64'd0, 1'b0, 1'b0, msca_pkg::SZ_64, 1'b1, msca_pkg::ST_OK}},
		'{'{4'd15, 64'hffff_ffff_ffff_ffff, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1}, 1'b1, '0}
	};

	// stimulus: reset, directed table, random body with a drain pause midway
	initial begin
		alu_req_t t;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[i]) begin
			send_alu(directed_rows[i].req);
			// typed rows replace the predicted expectation with the written one
			if (directed_rows[i].typed)
				expected_results[$] = directed_rows[i].rsp;
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			// drain pause: hold requests until every transaction has returned
			if (n == N_RANDOM / 2) begin
				req_valid <= 1'b0;
				@(negedge clk);
				while (expected_results.size() != 0) @(negedge clk);
			end
			t.op = 4'($urandom_range(0, 15));
			t.a = rand_operand();
			t.as = 1'($urandom_range(0, 1));
			t.b = ($urandom_range(0, 5) == 0) ? 64'd0 : rand_operand();
			t.bs = 1'($urandom_range(0, 1));
			send_alu(t);
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// long response hold-off while requests keep coming, so the pipe fills
	initial begin
		wait (arst_n);
		repeat (200) @(negedge clk);
		hold_off = 1'b1;
		repeat (12 * LATENCY) @(negedge clk);
		hold_off = 1'b0;
	end

	// response side stalls: random waits per transaction, some runs with none
	initial begin
		int wait_cycles;
		wait (arst_n);
		forever begin
			@(negedge clk);
			wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
			if (wait_cycles > 0 || hold_off) begin
				rsp_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
				while (hold_off) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// compare every accepted response with the oldest expectation
	always @(posedge clk) begin
		alu_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$error("response with no transaction outstanding");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result_value !== want.value) begin
					$error("result_value exp %h got %h", want.value, result_value);
					errors++;
				end
				if (result_signed !== want.sgn) begin
					$error("result_signed exp %b got %b", want.sgn, result_signed);
					errors++;
				end
				if (compare_true !== want.truth) begin
					$error("compare_true exp %b got %b", want.truth, compare_true);
					errors++;
				end
				if (size_code !== want.code) begin
					$error("size_code exp %d got %d", want.code, size_code);
					errors++;
				end
				if (size_valid !== want.valid) begin
					$error("size_valid exp %b got %b", want.valid, size_valid);
					errors++;
				end
				if (status !== want.status) begin
					$error("status exp %d got %d", want.status, status);
					errors++;
				end
			end
		end
	end

	// end of run: drain, allow the pipeline latency for strays, then report
	initial begin
		wait (stim_done);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (2 * LATENCY) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// timeout well beyond the slowest legitimate run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== mixed_sign_checked_alu.f =====
src/msca_pkg.sv
src/msca_front.sv
src/msca_cell.sv
src/msca_back.sv
src/mixed_sign_checked_alu.sv
bench/testbench.sv
